>>> design/conv2d_valid_stream_assert.svh
// ----------------------------------------------------------------------------
// conv2d_valid_stream assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CONV2D_VALID_STREAM_ASSERT_SVH
`define CONV2D_VALID_STREAM_ASSERT_SVH

// same-cycle implication, reset masked
`define CVS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define CVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg
// shared types and codes of the streaming valid convolution
// ----------------------------------------------------------------------------
package cvs_pkg;

	// input opcodes
	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd2;
	localparam logic [2:0] CFG_KERNEL_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_KERNEL_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_UNIT_COUNT    = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int MAX_HEIGHT = 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_RESULT
	} cvs_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept_weight;
		logic accept_sample;
		logic issue;
		logic load_out;
	} cvs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic term_last;
		logic unit_last;
		logic pipe_busy;
		logic out_free;
	} cvs_sts_t;

endpackage

>>> design/conv2d_valid_stream.sv
// ----------------------------------------------------------------------------
// conv2d_valid_stream
// valid stride-1 2d convolution over channel-last sample streams
// ----------------------------------------------------------------------------
// A weight request (opcode 0) writes one kernel entry; a sample request
// (opcode 1) is written into the circular line store. When the sample is the
// last channel of a pixel that closes a full window, the block then computes
// one sum per unit on a single shared multiply-accumulate fed by one read
// port of each store: each unit issues kernel_height * kernel_width *
// channel_count terms, drains the pipeline and hands off its result once the
// output register is free, so such a sample holds the input until the last
// unit is loaded, and a result-side stall can hold it longer. Results leave
// through an output register, so the input is taken again as soon as the
// last unit is loaded, even while that result is still stalled. A write to
// configuration index 0 to 5 restarts the image at row, column and channel
// zero. Neither store is cleared after reset; kernel entries must be loaded
// before they are used.
module conv2d_valid_stream import cvs_pkg::*; #(
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_KERNEL   = 5,
	parameter int MAX_UNITS    = 16,
	parameter int FRAC_BITS    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [12:0]           weight_index,
	input  logic signed [15:0]    data_value,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    conv_sum,
	output logic [3:0]            unit_index,
	output logic [5:0]            out_row,
	output logic [5:0]            out_col,
	output logic                  saturated,
	output logic                  last_unit,
	output logic                  last_of_image
);

	cvs_cmd_t cmd;
	cvs_sts_t sts;

	// sequencer: intake while idle, then issue, drain and unload per unit
	cvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, positions, mac pipeline and output register
	cvs_datapath #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_KERNEL   (MAX_KERNEL),
		.MAX_UNITS    (MAX_UNITS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.weight_index  (weight_index),
		.data_value    (data_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.conv_sum      (conv_sum),
		.unit_index    (unit_index),
		.out_row       (out_row),
		.out_col       (out_col),
		.saturated     (saturated),
		.last_unit     (last_unit),
		.last_of_image (last_of_image)
	);

endmodule

>>> design/cvs_datapath.sv
// ----------------------------------------------------------------------------
// cvs_datapath
// stores, position counters, shared multiply-accumulate and result register
// ----------------------------------------------------------------------------
module cvs_datapath import cvs_pkg::*; #(
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_KERNEL   = 5,
	parameter int MAX_UNITS    = 16,
	parameter int FRAC_BITS    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [12:0]           weight_index,
	input  logic signed [15:0]    data_value,
	input  cvs_cmd_t              cmd,
	output cvs_sts_t              sts,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic signed [31:0]    conv_sum,
	output logic [3:0]            unit_index,
	output logic [5:0]            out_row,
	output logic [5:0]            out_col,
	output logic                  saturated,
	output logic                  last_unit,
	output logic                  last_of_image
);

	localparam int W_DEPTH = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS * MAX_UNITS;
	localparam int L_DEPTH = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
	localparam int ROW_STRIDE = MAX_WIDTH * MAX_CHANNELS;
	localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int LAW = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;
	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int KW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int UW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int IWW = $clog2(MAX_WIDTH + 1);
	localparam int CCW = $clog2(MAX_CHANNELS + 1);
	localparam int KCW = $clog2(MAX_KERNEL + 1);
	localparam int UCW = $clog2(MAX_UNITS + 1);
	localparam int AW  = 33 + $clog2(MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS + 1);
	localparam logic signed [AW-1:0] SUM_MAX = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] SUM_MIN = AW'(-64'sd2147483648);

	// configuration, clamped on write
	logic [IWW-1:0] iw_q;
	logic [6:0]     ih_q;
	logic [CCW-1:0] cc_q;
	logic [KCW-1:0] kh_q, kw_q;
	logic [UCW-1:0] uc_q;

	// stream position
	logic [5:0]     row_q;
	logic [CW-1:0]  col_q;
	logic [CHW-1:0] chan_q;
	logic [KW-1:0]  row_slot_q;

	// window in flight
	logic [5:0]    r0_q;
	logic [CW-1:0] c0_q;
	logic          img_end_q;
	logic [UW-1:0] u_q;
	logic [KW-1:0] kr_q, kc_q, slot_q;
	logic [CHW-1:0] c_q;
	logic [WAW-1:0] wa_q;
	logic [KW-1:0]  start_slot;
	logic [KW-1:0]  start_slot_q;

	logic signed [15:0] weight_mem [W_DEPTH];
	logic signed [15:0] line_mem [L_DEPTH];
	logic signed [15:0] x_s1, w_s1;
	logic               v_s1, v_s2;
	logic signed [31:0] prod_s2;
	logic signed [AW-1:0] acc_q, shifted;

	logic [LAW-1:0] la_rd, la_wr;
	logic           row_ok, col_ok, chan_last, img_end;
	logic           out_valid_q, sat_next;
	logic signed [31:0] sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= IWW'((MAX_WIDTH < 32) ? MAX_WIDTH : 32);
			ih_q <= 7'd32;
			cc_q <= CCW'(1);
			kh_q <= KCW'((MAX_KERNEL < 3) ? MAX_KERNEL : 3);
			kw_q <= KCW'((MAX_KERNEL < 3) ? MAX_KERNEL : 3);
			uc_q <= UCW'((MAX_UNITS < 8) ? MAX_UNITS : 8);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					iw_q <= (cfg_data == '0) ? IWW'(1) :
						(32'(cfg_data) > MAX_WIDTH) ? IWW'(MAX_WIDTH) : IWW'(cfg_data);
				end
				CFG_IMAGE_HEIGHT: begin
					ih_q <= (cfg_data == '0) ? 7'd1 :
						(32'(cfg_data) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg_data;
				end
				CFG_CHANNEL_COUNT: begin
					cc_q <= (cfg_data == '0) ? CCW'(1) :
						(32'(cfg_data) > MAX_CHANNELS) ? CCW'(MAX_CHANNELS) : CCW'(cfg_data);
				end
				CFG_KERNEL_HEIGHT: begin
					kh_q <= (cfg_data == '0) ? KCW'(1) :
						(32'(cfg_data) > MAX_KERNEL) ? KCW'(MAX_KERNEL) : KCW'(cfg_data);
				end
				CFG_KERNEL_WIDTH: begin
					kw_q <= (cfg_data == '0) ? KCW'(1) :
						(32'(cfg_data) > MAX_KERNEL) ? KCW'(MAX_KERNEL) : KCW'(cfg_data);
				end
				CFG_UNIT_COUNT: begin
					uc_q <= (cfg_data == '0) ? UCW'(1) :
						(32'(cfg_data) > MAX_UNITS) ? UCW'(MAX_UNITS) : UCW'(cfg_data);
				end
				default: ;
			endcase
		end
	end

	assign chan_last = (32'(chan_q) + 32'd1 == 32'(cc_q));
	assign row_ok    = (32'(row_q) + 32'd1 >= 32'(kh_q));
	assign col_ok    = (32'(col_q) + 32'd1 >= 32'(kw_q));
	assign img_end   = (32'(row_q) + 32'd1 >= 32'(ih_q)) && (32'(col_q) + 32'd1 >= 32'(iw_q));

	// any legal write restarts the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			chan_q     <= '0;
			row_slot_q <= '0;
		end else if (cfg_we && 32'(cfg_index) <= 32'(CFG_UNIT_COUNT)) begin
			row_q      <= '0;
			col_q      <= '0;
			chan_q     <= '0;
			row_slot_q <= '0;
		end else if (cmd.accept_sample) begin
			if (chan_last) begin
				chan_q <= '0;
				if (32'(col_q) + 32'd1 >= 32'(iw_q)) begin
					col_q <= '0;
					if (32'(row_q) + 32'd1 >= 32'(ih_q)) begin
						row_q      <= '0;
						row_slot_q <= '0;
					end else begin
						row_q      <= row_q + 6'd1;
						row_slot_q <= (32'(row_slot_q) == MAX_KERNEL - 1) ? '0
							: KW'(32'(row_slot_q) + 32'd1);
					end
				end else begin
					col_q <= CW'(32'(col_q) + 32'd1);
				end
			end else begin
				chan_q <= CHW'(32'(chan_q) + 32'd1);
			end
		end
	end

	// oldest window row in the circular line store
	always_comb begin
		logic [31:0] s;
		s = 32'(row_slot_q) + MAX_KERNEL - (32'(kh_q) - 32'd1);
		if (s >= MAX_KERNEL) s = s - MAX_KERNEL;
		start_slot = KW'(s);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_sample && sts.hit) begin
			r0_q      <= 6'(32'(row_q) + 32'd1 - 32'(kh_q));
			c0_q      <= CW'(32'(col_q) + 32'd1 - 32'(kw_q));
			img_end_q <= img_end;
		end
	end

	// term and unit counters, weight address steps by unit count
	always_ff @(posedge clk) begin
		if (cmd.accept_sample && sts.hit) begin
			u_q    <= '0;
			kr_q   <= '0;
			kc_q   <= '0;
			c_q    <= '0;
			slot_q <= start_slot;
			wa_q   <= '0;
		end else if (cmd.load_out && !sts.unit_last) begin
			u_q    <= UW'(32'(u_q) + 32'd1);
			kr_q   <= '0;
			kc_q   <= '0;
			c_q    <= '0;
			slot_q <= start_slot_q;
			wa_q   <= WAW'(32'(u_q) + 32'd1);
		end else if (cmd.issue) begin
			wa_q <= WAW'(32'(wa_q) + 32'(uc_q));
			if (32'(c_q) + 32'd1 == 32'(cc_q)) begin
				c_q <= '0;
				if (32'(kc_q) + 32'd1 == 32'(kw_q)) begin
					kc_q   <= '0;
					kr_q   <= KW'(32'(kr_q) + 32'd1);
					slot_q <= (32'(slot_q) == MAX_KERNEL - 1) ? '0 : KW'(32'(slot_q) + 32'd1);
				end else begin
					kc_q <= KW'(32'(kc_q) + 32'd1);
				end
			end else begin
				c_q <= CHW'(32'(c_q) + 32'd1);
			end
		end
	end

	// first slot is kept so later units restart the same window
	always_ff @(posedge clk) begin
		if (cmd.accept_sample && sts.hit) start_slot_q <= start_slot;
	end

	assign la_wr = LAW'(32'(row_slot_q) * ROW_STRIDE + 32'(col_q) * MAX_CHANNELS + 32'(chan_q));
	assign la_rd = LAW'(32'(slot_q) * ROW_STRIDE + (32'(c0_q) + 32'(kc_q)) * MAX_CHANNELS
		+ 32'(c_q));

	always_ff @(posedge clk) begin
		if (cmd.accept_weight && 32'(weight_index) < W_DEPTH)
			weight_mem[WAW'(weight_index)] <= data_value;
		w_s1 <= weight_mem[wa_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_sample) line_mem[la_wr] <= data_value;
		x_s1 <= line_mem[la_rd];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= x_s1 * w_s1;
		if ((cmd.accept_sample && sts.hit) || (cmd.load_out && !sts.unit_last))
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + AW'(prod_s2);
	end

	// floor shift then clip to 32 bits
	always_comb begin
		shifted  = acc_q >>> FRAC_BITS;
		sat_next = 1'b0;
		sum_next = 32'(shifted);
		if (shifted > SUM_MAX) begin
			sum_next = 32'sh7fffffff;
			sat_next = 1'b1;
		end else if (shifted < SUM_MIN) begin
			sum_next = 32'sh80000000;
			sat_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			conv_sum      <= sum_next;
			saturated     <= sat_next;
			unit_index    <= 4'(u_q);
			out_row       <= r0_q;
			out_col       <= 6'(c0_q);
			last_unit     <= sts.unit_last;
			last_of_image <= sts.unit_last && img_end_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.hit       = chan_last && row_ok && col_ok;
	assign sts.term_last = (32'(c_q) + 32'd1 == 32'(cc_q)) && (32'(kc_q) + 32'd1 == 32'(kw_q))
		&& (32'(kr_q) + 32'd1 == 32'(kh_q));
	assign sts.unit_last = (32'(u_q) + 32'd1 == 32'(uc_q));
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

>>> design/cvs_ctrl.sv
// ----------------------------------------------------------------------------
// cvs_ctrl
// sequencer for request intake, term issue, drain and result hand-off
// ----------------------------------------------------------------------------
module cvs_ctrl import cvs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     opcode,
	output logic     in_stall,
	input  cvs_sts_t sts,
	output cvs_cmd_t cmd
);

	cvs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (opcode == OP_WEIGHT) begin
						cmd.accept_weight = 1'b1;
					end else begin
						cmd.accept_sample = 1'b1;
						if (sts.hit) state_d = ST_ISSUE;
					end
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.term_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = sts.unit_last ? ST_IDLE : ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> design/cvs_checker.sv
// ----------------------------------------------------------------------------
// cvs_checker
// port-level checks bound onto the convolution top level
// ----------------------------------------------------------------------------
`include "conv2d_valid_stream_assert.svh"

module cvs_checker import cvs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  opcode,
	input logic [12:0]           weight_index,
	input logic signed [15:0]    data_value,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic signed [31:0]    conv_sum,
	input logic [3:0]            unit_index,
	input logic [5:0]            out_row,
	input logic [5:0]            out_col,
	input logic                  saturated,
	input logic                  last_unit,
	input logic                  last_of_image
);

	`CVS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(conv_sum), "result changed while stalled")
	`CVS_ASSERT_NOW(a_image_end_unit, out_valid && last_of_image, last_unit, "image end off the final unit")
	`CVS_ASSERT_NOW(a_sat_clip, out_valid && saturated, conv_sum == 32'sh7fffffff || conv_sum == 32'sh80000000, "saturated sum not at a limit")
	`CVS_ASSERT_NEXT(a_weight_quick, in_valid && !in_stall && opcode == OP_WEIGHT, !in_stall, "weight load held the input")

endmodule

bind conv2d_valid_stream cvs_checker u_cvs_checker (.*);

>>> tb/tb_conv2d_valid_stream.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv2d_valid_stream
// self-checking bench for the streaming valid convolution: weight and sample
// requests under random gaps and result stalls, every result compared field
// by field against a bit-accurate software copy of the block
// ----------------------------------------------------------------------------
module tb_conv2d_valid_stream;
	import cvs_pkg::*;

	localparam int K_MAX      = 5;
	localparam int W_MAX      = 64;
	localparam int C_MAX      = 16;
	localparam int U_MAX      = 16;
	localparam int KSTORE_N   = K_MAX * K_MAX * C_MAX * U_MAX;
	localparam int LSTORE_N   = K_MAX * W_MAX * C_MAX;
	// largest kh * kw * channels * units of any shape below that streams samples
	localparam int WLOAD_N    = 25;
	localparam int CYCLE_CAP  = 1000000;
	localparam int DRAIN_WAIT = 50;

	typedef struct packed {
		logic signed [31:0] conv_sum;
		logic [3:0]         unit_index;
		logic [5:0]         out_row;
		logic [5:0]         out_col;
		logic               saturated;
		logic               last_unit;
		logic               last_of_image;
	} conv_result_t;

	// software copy of the convolution and the queue of sums it predicts
	class conv_scoreboard;
		logic signed [15:0] kernel_mem [KSTORE_N];
		logic signed [15:0] line_mem [LSTORE_N];
		int unsigned        row_at, col_at, chan_at;
		int unsigned        img_w, img_h, chans, ker_h, ker_w, units;
		conv_result_t       pending_sums [$];
		int                 fails;

		function new();
			row_at = 0; col_at = 0; chan_at = 0;
			img_w = 32; img_h = 32; chans = 1; ker_h = 3; ker_w = 3; units = 8;
			fails = 0;
		endfunction

		function int unsigned clip(int unsigned v, int unsigned hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_IMAGE_WIDTH:   img_w = clip(32'(val), W_MAX);
				CFG_IMAGE_HEIGHT:  img_h = clip(32'(val), MAX_HEIGHT);
				CFG_CHANNEL_COUNT: chans = clip(32'(val), C_MAX);
				CFG_KERNEL_HEIGHT: ker_h = clip(32'(val), K_MAX);
				CFG_KERNEL_WIDTH:  ker_w = clip(32'(val), K_MAX);
				CFG_UNIT_COUNT:    units = clip(32'(val), U_MAX);
				default:           return;
			endcase
			row_at = 0; col_at = 0; chan_at = 0;
		endfunction

		// one accepted request
		function void note_request(logic op, logic [12:0] widx, logic signed [15:0] val);
			int unsigned r0, c0, la, wa;
			longint      acc, s;
			bit          img_end;
			conv_result_t res;
			if (op == OP_WEIGHT) begin
				if (widx < KSTORE_N) kernel_mem[widx] = val;
				return;
			end
			line_mem[13'(((row_at % K_MAX) * W_MAX + col_at) * C_MAX + chan_at)] = val;
			if (chan_at + 1 >= chans && row_at + 1 >= ker_h && col_at + 1 >= ker_w) begin
				r0 = row_at + 1 - ker_h;
				c0 = col_at + 1 - ker_w;
				img_end = (row_at + 1 >= img_h) && (col_at + 1 >= img_w);
				for (int u = 0; u < units; u++) begin
					acc = 0;
					for (int kr = 0; kr < ker_h; kr++)
						for (int kc = 0; kc < ker_w; kc++)
							for (int c = 0; c < chans; c++) begin
								la = (((r0 + kr) % K_MAX) * W_MAX + c0 + kc) * C_MAX + c;
								wa = ((kr * ker_w + kc) * chans + c) * units + u;
								acc += longint'(line_mem[13'(la)]) * longint'(kernel_mem[13'(wa)]);
							end
					s = acc >>> 8;   // floor shift of the Q16.16 sum
					res.saturated = 1'b0;
					if (s > 64'sd2147483647) begin
						s = 64'sd2147483647; res.saturated = 1'b1;
					end
					if (s < -64'sd2147483648) begin
						s = -64'sd2147483648; res.saturated = 1'b1;
					end
					res.conv_sum      = s[31:0];
					res.unit_index    = u[3:0];
					res.out_row       = r0[5:0];
					res.out_col       = c0[5:0];
					res.last_unit     = (u + 1 == units);
					res.last_of_image = img_end && (u + 1 == units);
					pending_sums.push_back(res);
				end
			end
			chan_at++;
			if (chan_at >= chans) begin
				chan_at = 0;
				col_at++;
				if (col_at >= img_w) begin
					col_at = 0;
					row_at++;
					if (row_at >= img_h) row_at = 0;
				end
			end
		endfunction

		function void check_result(conv_result_t got);
			conv_result_t exp_r;
			if (pending_sums.size() == 0) begin
				$error("unexpected result sum=%0d unit=%0d", got.conv_sum, got.unit_index);
				fails++;
				return;
			end
			exp_r = pending_sums.pop_front();
			if (got.conv_sum !== exp_r.conv_sum) begin
				$error("conv_sum exp %0d got %0d", exp_r.conv_sum, got.conv_sum); fails++;
			end
			if (got.unit_index !== exp_r.unit_index) begin
				$error("unit_index exp %0d got %0d", exp_r.unit_index, got.unit_index); fails++;
			end
			if (got.out_row !== exp_r.out_row) begin
				$error("out_row exp %0d got %0d", exp_r.out_row, got.out_row); fails++;
			end
			if (got.out_col !== exp_r.out_col) begin
				$error("out_col exp %0d got %0d", exp_r.out_col, got.out_col); fails++;
			end
			if (got.saturated !== exp_r.saturated) begin
				$error("saturated exp %0d got %0d", exp_r.saturated, got.saturated); fails++;
			end
			if (got.last_unit !== exp_r.last_unit) begin
				$error("last_unit exp %0d got %0d", exp_r.last_unit, got.last_unit); fails++;
			end
			if (got.last_of_image !== exp_r.last_of_image) begin
				$error("last_of_image exp %0d got %0d", exp_r.last_of_image,
					got.last_of_image);
				fails++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  opcode;
	logic [12:0]           weight_index;
	logic signed [15:0]    data_value;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [31:0]    conv_sum;
	logic [3:0]            unit_index;
	logic [5:0]            out_row;
	logic [5:0]            out_col;
	logic                  saturated;
	logic                  last_unit;
	logic                  last_of_image;

	conv_scoreboard sb = new();
	int unsigned    cycle_count = 0;

	conv2d_valid_stream dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .weight_index(weight_index), .data_value(data_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.conv_sum(conv_sum), .unit_index(unit_index), .out_row(out_row),
		.out_col(out_col), .saturated(saturated), .last_unit(last_unit),
		.last_of_image(last_of_image)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{conv_sum, unit_index, out_row, out_col,
				saturated, last_unit, last_of_image});
	end

	// result stall pattern: free runs, short stalls and the odd long one
	initial begin
		int unsigned run, pick;
		out_stall = 1'b0;
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				out_stall = 1'b0; run = $urandom_range(1, 20);
			end else if (pick < 95) begin
				out_stall = 1'b1; run = $urandom_range(1, 3);
			end else begin
				out_stall = 1'b1; run = $urandom_range(15, 40);
			end
			repeat (run) @(negedge clk);
		end
	end

	// gap before a request: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// sample or weight value with the extremes showing up often
	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// one request, held until accepted; valid stays up across back-to-back requests
	task automatic send_req(logic op, logic [12:0] widx, logic signed [15:0] val,
			int unsigned gap);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		opcode       = op;
		weight_index = widx;
		data_value   = val;
		do @(posedge clk); while (in_stall);
		sb.note_request(op, widx, val);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		in_valid  = 1'b0;
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// let every expected sum come out, then a margin, before touching registers
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending_sums.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_shape(int w, int h, int ch, int kh, int kw, int u);
		settle();
		write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
		write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(ch));
		write_reg(CFG_KERNEL_HEIGHT, CFG_DATA_W'(kh));
		write_reg(CFG_KERNEL_WIDTH, CFG_DATA_W'(kw));
		write_reg(CFG_UNIT_COUNT, CFG_DATA_W'(u));
	endtask

	// samples with a sprinkle of weight rewrites over the whole index range
	task automatic stream_phase(int unsigned n_samples);
		int unsigned sent;
		sent = 0;
		while (sent < n_samples) begin
			if ($urandom_range(0, 9) == 0)
				send_req(OP_WEIGHT, 13'($urandom_range(0, 8191)), pick_value(), pick_gap());
			else begin
				send_req(OP_SAMPLE, 13'($urandom), pick_value(), pick_gap());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		opcode       = OP_WEIGHT;
		weight_index = '0;
		data_value   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// load every kernel entry that the shapes below read
		for (int i = 0; i < WLOAD_N; i++)
			send_req(OP_WEIGHT, 13'(i), pick_value(), ($urandom_range(0, 19) == 0) ? 2 : 0);

		// directed: out-of-range register values clamp
		set_shape(0, 127, 0, 7, 0, 127);
		// indexes past the store are ignored
		send_req(OP_WEIGHT, 13'd6400, 16'sh7fff, 0);
		send_req(OP_WEIGHT, 13'd8191, 16'sh8000, 0);
		// 1x1 pixel images, 4 channels, 4 units: every pixel ends an image
		set_shape(1, 1, 4, 1, 1, 4);
		for (int i = 0; i < 16; i++)
			send_req(OP_SAMPLE, 13'd0, (i % 2) ? 16'sh8000 : 16'sh7fff, 0);

		// 3x3 image with a 3x3 kernel: single window at the image end
		set_shape(3, 3, 1, 3, 3, 2);
		for (int i = 0; i < 9; i++)
			send_req(OP_SAMPLE, 13'h1fff, (i < 5) ? 16'sh8000 : 16'sh0000, pick_gap());

		// kernel taller than the image: nothing comes out
		set_shape(2, 2, 1, 3, 1, 1);
		for (int i = 0; i < 4; i++) send_req(OP_SAMPLE, 13'd0, pick_value(), 0);

		// largest kernel over a 5x5 image
		set_shape(5, 5, 1, 5, 5, 1);
		stream_phase(25);

		// random shapes, kernels sometimes larger than the image
		for (int p = 0; p < 4; p++) begin
			set_shape($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 2),
				$urandom_range(1, 2), $urandom_range(1, 2), $urandom_range(1, 3));
			stream_phase(8);
		end

		settle();
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
